/* rtl/text_console_writer_macros.svh */
// assertion macros for the text console writer
// used by text_console_writer.sv, no other dependencies
`ifndef TEXT_CONSOLE_WRITER_MACROS_SVH
`define TEXT_CONSOLE_WRITER_MACROS_SVH

// condition holds in the same cycle
`define TCW_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// condition holds in the following cycle
`define TCW_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/tcw_pkg.sv */
// types, codes and microprogram table of the text console writer
// no dependencies; used by text_console_writer.sv
`timescale 1ns / 1ps

package tcw_pkg;

  // request function codes
  localparam logic [1:0] FUNC_PUT   = 2'd0;
  localparam logic [1:0] FUNC_CLEAR = 2'd1;
  localparam logic [1:0] FUNC_READ  = 2'd2;

  // character and attribute constants
  localparam logic [7:0] SPACE_CODE   = 8'h20;
  localparam logic [7:0] NEWLINE_CODE = 8'h0A;
  localparam logic [7:0] RETURN_CODE  = 8'h0D;
  localparam logic [7:0] RESET_ATTR   = 8'h0F;

  // microprogram step addresses
  typedef enum logic [3:0] {
    ST_RST_FILL,
    ST_IDLE,
    ST_PUT,
    ST_NEWLINE,
    ST_COPY_PRIME,
    ST_COPY,
    ST_COPY_LAST,
    ST_FILL,
    ST_CLEAR,
    ST_READ,
    ST_DONE
  } step_t;

  // screen store operation
  typedef enum logic [2:0] {
    MEM_NONE,
    MEM_WR_RESET,
    MEM_WR_BLANK,
    MEM_WR_CHAR,
    MEM_RD_IDX,
    MEM_COPY_PRIME,
    MEM_COPY,
    MEM_COPY_LAST
  } mem_op_t;

  // cell counter operation
  typedef enum logic [1:0] {
    CNT_HOLD,
    CNT_CLEAR,
    CNT_INC
  } cnt_op_t;

  // cursor operation
  typedef enum logic [1:0] {
    CUR_HOLD,
    CUR_HOME,
    CUR_COL_INC,
    CUR_NEWLINE
  } cur_op_t;

  // counter end limit
  typedef enum logic {
    LIM_COPY,
    LIM_ALL
  } lim_t;

  // jump condition: go_true when it holds, else go_false
  typedef enum logic [2:0] {
    COND_ALWAYS,
    COND_DISPATCH,
    COND_COL_NOT_LAST,
    COND_ROW_NOT_LAST,
    COND_CNT_NOT_END
  } cond_t;

  // one control word
  typedef struct packed {
    mem_op_t mem;
    cnt_op_t cnt;
    cur_op_t cur;
    lim_t    lim;
    cond_t   cond;
    step_t   go_true;
    step_t   go_false;
  } ctrl_t;

  // microprogram rom
  function automatic ctrl_t ucode(input step_t s);
    ctrl_t w;
    w.mem      = MEM_NONE;
    w.cnt      = CNT_HOLD;
    w.cur      = CUR_HOLD;
    w.lim      = LIM_ALL;
    w.cond     = COND_ALWAYS;
    w.go_true  = ST_IDLE;
    w.go_false = ST_IDLE;
    unique case (s)
      ST_RST_FILL: begin
        w.mem = MEM_WR_RESET; w.cnt = CNT_INC; w.cond = COND_CNT_NOT_END;
        w.go_true = ST_RST_FILL;
      end
      ST_IDLE: begin
        w.cnt = CNT_CLEAR; w.cond = COND_DISPATCH;
      end
      ST_PUT: begin
        w.mem = MEM_WR_CHAR; w.cur = CUR_COL_INC; w.cond = COND_COL_NOT_LAST;
        w.go_false = ST_NEWLINE;
      end
      ST_NEWLINE: begin
        w.cur = CUR_NEWLINE; w.cond = COND_ROW_NOT_LAST;
        w.go_false = ST_COPY_PRIME;
      end
      ST_COPY_PRIME: begin
        w.mem = MEM_COPY_PRIME; w.cnt = CNT_INC; w.go_true = ST_COPY;
      end
      ST_COPY: begin
        w.mem = MEM_COPY; w.cnt = CNT_INC; w.lim = LIM_COPY;
        w.cond = COND_CNT_NOT_END; w.go_true = ST_COPY; w.go_false = ST_COPY_LAST;
      end
      ST_COPY_LAST: begin
        w.mem = MEM_COPY_LAST; w.go_true = ST_FILL;
      end
      ST_FILL: begin
        w.mem = MEM_WR_BLANK; w.cnt = CNT_INC; w.cond = COND_CNT_NOT_END;
        w.go_true = ST_FILL;
      end
      ST_CLEAR: begin
        w.cur = CUR_HOME; w.go_true = ST_FILL;
      end
      ST_READ: begin
        w.mem = MEM_RD_IDX;
      end
      ST_DONE: begin
        w.cond = COND_ALWAYS;
      end
      default: begin
        w.cond = COND_ALWAYS;
      end
    endcase
    return w;
  endfunction

endpackage

/* rtl/text_console_writer.sv */
// text console writer: screen store, cursor and microcoded control
// depends on tcw_pkg.sv and text_console_writer_macros.svh
`timescale 1ns / 1ps
`include "text_console_writer_macros.svh"

// Text console engine with a COLUMNS x ROWS screen store in one single-port-write
// memory. A request is taken when start is high and busy is low; its result shows
// for one cycle with done high and cannot be held off, and the next request may be
// issued in that same cycle. Scrolling moves the store one cell per cycle through
// the memory's one write port and then blanks the last row; a clear homes the
// cursor and blanks every cell. After reset a clearing pass fills the store with
// blanks, busy stays high; attribute writes are taken throughout.
module text_console_writer #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic        clk,
  input  logic        rst,
  // request channel
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  func,
  input  logic [7:0]  char_code,
  input  logic [10:0] cell_index,
  // result channel
  output logic        done,
  output logic [10:0] cursor_position,
  output logic [15:0] cell_data,
  output logic        scrolled,
  // attribute register write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data
);

  localparam int CELLS  = COLUMNS * ROWS;
  localparam int ADDR_W = $clog2(CELLS);
  localparam int COL_W  = $clog2(COLUMNS);
  localparam int ROW_W  = $clog2(ROWS);
  localparam logic [COL_W-1:0]  COL_LAST  = COL_W'(COLUMNS - 1);
  localparam logic [ROW_W-1:0]  ROW_LAST  = ROW_W'(ROWS - 1);
  localparam logic [ADDR_W-1:0] END_ALL   = ADDR_W'(CELLS - 1);
  localparam logic [ADDR_W-1:0] END_COPY  = ADDR_W'(CELLS - COLUMNS - 1);
  localparam logic [ADDR_W-1:0] ROW_SPAN  = ADDR_W'(COLUMNS);

  // sequencer and datapath registers
  tcw_pkg::step_t       step, step_next;
  tcw_pkg::ctrl_t       ctl;
  logic [ADDR_W-1:0]    cnt;
  logic [COL_W-1:0]     col;
  logic [ROW_W-1:0]     row;
  logic [7:0]           attribute;
  logic [7:0]           char_reg;
  logic [10:0]          idx_reg;
  logic                 read_hit;
  logic                 scroll_flag;
  logic [15:0]          rd_data;
  logic [15:0]          screen_cells [CELLS];

  // memory port controls
  logic                 we, re;
  logic [ADDR_W-1:0]    waddr, raddr;
  logic [15:0]          wdata;
  logic [ADDR_W-1:0]    pos;
  logic [ADDR_W-1:0]    cnt_end;
  logic                 accept;
  logic                 done_next;

  assign accept    = start && !busy;
  assign busy      = (step != tcw_pkg::ST_IDLE);
  assign cfg_ready = 1'b1;
  assign ctl       = tcw_pkg::ucode(step);
  assign pos       = ADDR_W'(row * COLUMNS) + ADDR_W'(col);
  assign cnt_end   = (ctl.lim == tcw_pkg::LIM_COPY) ? END_COPY : END_ALL;

  // next step: conditional jump or dispatch on the request
  always_comb begin
    step_next = ctl.go_false;
    unique case (ctl.cond)
      tcw_pkg::COND_ALWAYS:       step_next = ctl.go_true;
      tcw_pkg::COND_COL_NOT_LAST: step_next = (col != COL_LAST) ? ctl.go_true : ctl.go_false;
      tcw_pkg::COND_ROW_NOT_LAST: step_next = (row != ROW_LAST) ? ctl.go_true : ctl.go_false;
      tcw_pkg::COND_CNT_NOT_END:  step_next = (cnt != cnt_end) ? ctl.go_true : ctl.go_false;
      tcw_pkg::COND_DISPATCH: begin
        if (accept) begin
          priority case (func)
            tcw_pkg::FUNC_PUT: begin
              priority if (char_code == tcw_pkg::RETURN_CODE) step_next = tcw_pkg::ST_DONE;
              else if (char_code == tcw_pkg::NEWLINE_CODE) step_next = tcw_pkg::ST_NEWLINE;
              else step_next = tcw_pkg::ST_PUT;
            end
            tcw_pkg::FUNC_CLEAR: step_next = tcw_pkg::ST_CLEAR;
            tcw_pkg::FUNC_READ:  step_next = tcw_pkg::ST_READ;
            default:             step_next = tcw_pkg::ST_DONE;
          endcase
        end
      end
      default: step_next = tcw_pkg::ST_IDLE;
    endcase
  end

  // result strobe on return to idle after a request
  assign done_next = (step != tcw_pkg::ST_IDLE) && (step != tcw_pkg::ST_RST_FILL) &&
                     (step_next == tcw_pkg::ST_IDLE);

  // screen store port decode
  always_comb begin
    we    = 1'b0;
    re    = 1'b0;
    waddr = cnt;
    raddr = ADDR_W'(cnt + ROW_SPAN);
    wdata = {attribute, tcw_pkg::SPACE_CODE};
    unique case (ctl.mem)
      tcw_pkg::MEM_NONE: ;
      tcw_pkg::MEM_WR_RESET: begin
        we    = 1'b1;
        wdata = {tcw_pkg::RESET_ATTR, tcw_pkg::SPACE_CODE};
      end
      tcw_pkg::MEM_WR_BLANK: we = 1'b1;
      tcw_pkg::MEM_WR_CHAR: begin
        we    = 1'b1;
        waddr = pos;
        wdata = {attribute, char_reg};
      end
      tcw_pkg::MEM_RD_IDX: begin
        re    = read_hit;
        raddr = ADDR_W'(idx_reg);
      end
      tcw_pkg::MEM_COPY_PRIME: re = 1'b1;
      tcw_pkg::MEM_COPY: begin
        we    = 1'b1;
        re    = 1'b1;
        waddr = cnt - 1'b1;
        wdata = rd_data;
      end
      tcw_pkg::MEM_COPY_LAST: begin
        we    = 1'b1;
        waddr = cnt - 1'b1;
        wdata = rd_data;
      end
      default: ;
    endcase
  end

  // screen store
  always_ff @(posedge clk) begin
    if (we) screen_cells[waddr] <= wdata;
    if (re) rd_data <= screen_cells[raddr];
  end

  // request payload capture
  always_ff @(posedge clk) begin
    if (accept) begin
      char_reg <= char_code;
      idx_reg  <= cell_index;
      read_hit <= (func == tcw_pkg::FUNC_READ) && (32'(cell_index) < CELLS);
    end
  end

  // sequencer, counter, cursor and attribute
  always_ff @(posedge clk) begin
    if (rst) begin
      step        <= tcw_pkg::ST_RST_FILL;
      cnt         <= '0;
      col         <= '0;
      row         <= '0;
      attribute   <= tcw_pkg::RESET_ATTR;
      done        <= 1'b0;
      scroll_flag <= 1'b0;
    end else begin
      step <= step_next;
      done <= done_next;
      if (cfg_valid && cfg_ready) attribute <= cfg_data;
      if (accept) scroll_flag <= 1'b0;
      unique case (ctl.cnt)
        tcw_pkg::CNT_HOLD:  ;
        tcw_pkg::CNT_CLEAR: cnt <= '0;
        tcw_pkg::CNT_INC:   cnt <= cnt + 1'b1;
        default: ;
      endcase
      unique case (ctl.cur)
        tcw_pkg::CUR_HOLD: ;
        tcw_pkg::CUR_HOME: begin
          col <= '0;
          row <= '0;
        end
        tcw_pkg::CUR_COL_INC: col <= (col == COL_LAST) ? '0 : col + 1'b1;
        tcw_pkg::CUR_NEWLINE: begin
          col <= '0;
          if (row != ROW_LAST) row <= row + 1'b1;
          else scroll_flag <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  // result ports
  assign cursor_position = 11'(pos);
  assign cell_data       = (done && read_hit) ? rd_data : 16'h0000;
  assign scrolled        = scroll_flag;

  // checks
  `TCW_ASSERT_NEXT(a_accept_busy, clk, rst, accept, busy, "accepted request did not start")
  `TCW_ASSERT_NEXT(a_done_single, clk, rst, done, !done, "result strobe held two cycles")
  `TCW_ASSERT_NOW(a_scroll_row, clk, rst, done && scrolled, row == ROW_LAST, "scroll off last row")

endmodule
